/* hdl/keyed_packet_descrambler_defines.svh */
// Assertion macros shared by the descrambler RTL.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef KEYED_PACKET_DESCRAMBLER_DEFINES_SVH
`define KEYED_PACKET_DESCRAMBLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/kpd_pkg.sv */
// Package for the keyed packet descrambler: types, constants and key ROM.
// Used by the interfaces, the parse step and the top level.
`timescale 1ns / 1ps

package kpd_pkg;

    // Message geometry limits.
    localparam int unsigned HEADER_BYTES  = 12;
    localparam int unsigned MAX_MSG_BYTES = 8192;

    localparam int unsigned INDEX_W   = 13;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_INIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CODE    = 1'd1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_CHECKSUM = 2'd1,
        ERR_INIT     = 2'd2,
        ERR_SIZE     = 2'd3
    } kpd_err_t;

    typedef struct packed {
        logic        init_pending;
        logic [31:0] init_shift;
        logic [1:0]  init_count;
        logic [15:0] byte_count;
        logic [15:0] message_size;
        logic [7:0]  key_position;
        logic [7:0]  expected_checksum;
        logic [7:0]  raw_sum;
        logic [7:0]  plain_sum;
    } kpd_state_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
        kpd_err_t           error_code;
        logic [31:0]        error_value;
    } kpd_result_t;

    // Key ROM: even entries seed the key position, odd entries are the taps.
    localparam logic [7:0] KEY_ROM [0:511] = '{
        8'h84,8'h87,8'h37,8'hd7,8'hea,8'h79,8'h91,8'h7d,8'h4b,8'h4b,8'h85,8'h7d,8'h87,8'h81,8'h91,8'h7c,
        8'h0f,8'h73,8'h91,8'h91,8'h87,8'h7d,8'h0d,8'h7d,8'h86,8'h8f,8'h73,8'h0f,8'he1,8'hdd,8'h85,8'h7d,
        8'h05,8'h7d,8'h85,8'h83,8'h87,8'h9c,8'h85,8'h33,8'h0d,8'he2,8'h87,8'h19,8'h0f,8'h79,8'h85,8'h86,
        8'h37,8'h7d,8'hd7,8'hdd,8'he9,8'h7d,8'hd7,8'h7d,8'h85,8'h79,8'h05,8'h7d,8'h0f,8'he1,8'h87,8'h7e,
        8'h23,8'h87,8'hf5,8'h79,8'h5f,8'he3,8'h4b,8'h83,8'ha3,8'ha2,8'hae,8'h0e,8'h14,8'h7d,8'hde,8'h7e,
        8'h85,8'h7a,8'h85,8'haf,8'hcd,8'h7d,8'h87,8'ha5,8'h87,8'h7d,8'he1,8'h7d,8'h88,8'h7d,8'h15,8'h91,
        8'h23,8'h7d,8'h87,8'h7c,8'h0d,8'h7a,8'h85,8'h87,8'h17,8'h7c,8'h85,8'h7d,8'hac,8'h80,8'hbb,8'h79,
        8'h84,8'h9b,8'h5b,8'ha5,8'hd7,8'h8f,8'h05,8'h0f,8'h85,8'h7e,8'h85,8'h80,8'h85,8'h98,8'hf5,8'h9d,
        8'ha3,8'h1a,8'h0d,8'h19,8'h87,8'h7c,8'h85,8'h7d,8'h84,8'h7d,8'h85,8'h7e,8'he7,8'h97,8'h0d,8'h0f,
        8'h85,8'h7b,8'hea,8'h7d,8'had,8'h80,8'had,8'h7d,8'hb7,8'haf,8'h0d,8'h7d,8'he9,8'h3d,8'h85,8'h7d,
        8'h87,8'hb7,8'h23,8'h7d,8'he7,8'hb7,8'ha3,8'h0c,8'h87,8'h7e,8'h85,8'ha5,8'h7d,8'h76,8'h35,8'hb9,
        8'h0d,8'h6f,8'h23,8'h7d,8'h87,8'h9b,8'h85,8'h0c,8'he1,8'ha1,8'h0d,8'h7f,8'h87,8'h7d,8'h84,8'h7a,
        8'h84,8'h7b,8'he1,8'h86,8'he8,8'h6f,8'hd1,8'h79,8'h85,8'h19,8'h53,8'h95,8'hc3,8'h47,8'h19,8'h7d,
        8'he7,8'h0c,8'h37,8'h7c,8'h23,8'h7d,8'h85,8'h7d,8'h4b,8'h79,8'h21,8'ha5,8'h87,8'h7d,8'h19,8'h7d,
        8'h0d,8'h7d,8'h15,8'h91,8'h23,8'h7d,8'h87,8'h7c,8'h85,8'h7a,8'h85,8'haf,8'hcd,8'h7d,8'h87,8'h7d,
        8'he9,8'h3d,8'h85,8'h7d,8'h15,8'h79,8'h85,8'h7d,8'hc1,8'h7b,8'hea,8'h7d,8'hb7,8'h7d,8'h85,8'h7d,
        8'h85,8'h7d,8'h0d,8'h7d,8'he9,8'h73,8'h85,8'h79,8'h05,8'h7d,8'hd7,8'h7d,8'h85,8'he1,8'hb9,8'he1,
        8'h0f,8'h65,8'h85,8'h86,8'h2d,8'h7d,8'hd7,8'hdd,8'ha3,8'h8e,8'he6,8'h7d,8'hde,8'h7e,8'hae,8'h0e,
        8'h0f,8'he1,8'h89,8'h7e,8'h23,8'h7d,8'hf5,8'h79,8'h23,8'he1,8'h4b,8'h83,8'h0c,8'h0f,8'h85,8'h7b,
        8'h85,8'h7e,8'h8f,8'h80,8'h85,8'h98,8'hf5,8'h7a,8'h85,8'h1a,8'h0d,8'he1,8'h0f,8'h7c,8'h89,8'h0c,
        8'h85,8'h0b,8'h23,8'h69,8'h87,8'h7b,8'h23,8'h0c,8'h1f,8'hb7,8'h21,8'h7a,8'h88,8'h7e,8'h8f,8'ha5,
        8'h7d,8'h80,8'hb7,8'hb9,8'h18,8'hbf,8'h4b,8'h19,8'h85,8'ha5,8'h91,8'h80,8'h87,8'h81,8'h87,8'h7c,
        8'h0f,8'h73,8'h91,8'h91,8'h84,8'h87,8'h37,8'hd7,8'h86,8'h79,8'he1,8'hdd,8'h85,8'h7a,8'h73,8'h9b,
        8'h05,8'h7d,8'h0d,8'h83,8'h87,8'h9c,8'h85,8'h33,8'h87,8'h7d,8'h85,8'h0f,8'h87,8'h7d,8'h0d,8'h7d,
        8'hf6,8'h7e,8'h87,8'h7d,8'h88,8'h19,8'h89,8'hf5,8'hd1,8'hdd,8'h85,8'h7d,8'h8b,8'hc3,8'hea,8'h7a,
        8'hd7,8'hb0,8'h0d,8'h7d,8'h87,8'ha5,8'h87,8'h7c,8'h73,8'h7e,8'h7d,8'h86,8'h87,8'h23,8'h85,8'h10,
        8'hd7,8'hdf,8'hed,8'ha5,8'he1,8'h7a,8'h85,8'h23,8'hea,8'h7e,8'h85,8'h98,8'had,8'h79,8'h86,8'h7d,
        8'h85,8'h7d,8'hd7,8'h7d,8'he1,8'h7a,8'hf5,8'h7d,8'h85,8'hb0,8'h2b,8'h37,8'he1,8'h7a,8'h87,8'h79,
        8'h84,8'h7d,8'h73,8'h73,8'h87,8'h7d,8'h23,8'h7d,8'he9,8'h7d,8'h85,8'h7e,8'h02,8'h7d,8'hdd,8'h2d,
        8'h87,8'h79,8'he7,8'h79,8'had,8'h7c,8'h23,8'hda,8'h87,8'h0d,8'h0d,8'h7b,8'he7,8'h79,8'h9b,8'h7d,
        8'hd7,8'h8f,8'h05,8'h7d,8'h0d,8'h34,8'h8f,8'h7d,8'had,8'h87,8'he9,8'h7c,8'h85,8'h80,8'h85,8'h79,
        8'h8a,8'hc3,8'he7,8'ha5,8'he8,8'h6b,8'h0d,8'h74,8'h10,8'h73,8'h33,8'h17,8'h0d,8'h37,8'h21,8'h19
    };

    // Start value of the key position for a key index (even ROM half).
    function automatic logic [7:0] key_start(input logic [7:0] key_index);
        return KEY_ROM[{key_index, 1'b0}];
    endfunction

    // Key tap for a key position (odd ROM half).
    function automatic logic [7:0] key_tap(input logic [7:0] key_pos);
        return KEY_ROM[{key_pos, 1'b1}];
    endfunction

    // Parse state after a connection restart.
    function automatic kpd_state_t restart_state(input logic require_init);
        kpd_state_t s;
        s = '0;
        s.init_pending = require_init;
        return s;
    endfunction

endpackage

/* hdl/kpd_if.sv */
// Handshake channels of the keyed packet descrambler.
// Depends on kpd_pkg for payload widths and the error code type.
`timescale 1ns / 1ps

// Received byte or restart request.
interface kpd_rx_if
    import kpd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink (input valid, action, rx_byte, output ready);
endinterface

// At most one result item per request.
interface kpd_res_if
    import kpd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [7:0]         data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last;
    kpd_err_t           error_code;
    logic [31:0]        error_value;

    modport source (output valid, data_byte, byte_index, last, error_code, error_value,
                    input ready);
    modport sink (input valid, data_byte, byte_index, last, error_code, error_value,
                  output ready);
endinterface

// Configuration register write request.
interface kpd_cfg_if
    import kpd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/keyed_packet_descrambler.sv */
// Keyed packet descrambler, top level: input stage, parse state, result register.
// Depends on kpd_pkg, the channel interfaces, kpd_step and the assertion macros.
//
// The block takes one received byte (or restart request) per clock cycle while
// the result slot is free, and gives at most one result per byte. A request is
// held in the input register; the parse step then updates the state and loads
// the result register, so a result passes through the input register and then
// the result register, and waits in the result register under back-pressure.
// The rate of one byte per cycle without back-pressure is set by the
// combinational parse step, whose state (byte count, key position, sums) feeds
// the next byte directly; the key ROM lookup, the adjustment add and both sum
// updates are combinational. Header bytes give a raw result; init-word bytes
// that match and restarts give no result, and a mismatching init word gives an
// ERR_INIT result. Configuration writes are accepted every cycle; writing
// require_init_word restarts the parser. There is no clearing pass after reset.
`timescale 1ns / 1ps
`include "keyed_packet_descrambler_defines.svh"

module keyed_packet_descrambler
    import kpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kpd_rx_if.sink    rx,
    kpd_res_if.source res,
    kpd_cfg_if.sink   cfg
);

    logic        require_init_reg;
    logic [31:0] init_code_reg;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_go;

    kpd_state_t  state_reg;
    kpd_state_t  state_next;
    logic        step_has_result;
    kpd_result_t step_result;

    logic        out_valid_reg;
    kpd_result_t out_reg;

    // Handshakes: the input register advances whenever the result slot is free.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready  = !s1_valid_reg || s1_go;
    assign cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_init_reg <= 1'b1;
            init_code_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_REQUIRE_INIT: require_init_reg <= cfg.data[0];
                CFG_INIT_CODE:    init_code_reg    <= cfg.data;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_action_reg <= rx.action;
            s1_byte_reg   <= rx.rx_byte;
        end
    end

    // Parse step.
    kpd_step u_step (
        .cur          (state_reg),
        .action       (s1_action_reg),
        .rx_byte      (s1_byte_reg),
        .require_init (require_init_reg),
        .init_code    (init_code_reg),
        .nxt          (state_next),
        .has_result   (step_has_result),
        .result       (step_result)
    );

    // Parse state; a write of require_init_word restarts the parser.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= restart_state(1'b1);
        end
        else if (cfg.valid && cfg.index == CFG_REQUIRE_INIT)
        begin
            state_reg <= restart_state(cfg.data[0]);
        end
        else if (s1_go)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= step_has_result;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && step_has_result)
        begin
            out_reg <= step_result;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.data_byte   = out_reg.data_byte;
    assign res.byte_index  = out_reg.byte_index;
    assign res.last        = out_reg.last;
    assign res.error_code  = out_reg.error_code;
    assign res.error_value = out_reg.error_value;

    // Checks on the parser and the stage handoff.
    `KPD_ASSERT_NOW(a_ok_has_no_value, out_valid_reg && out_reg.error_code == ERR_NONE,
        out_reg.error_value == 32'd0, "successful result carries an error value")
    `KPD_ASSERT_NOW(a_error_is_last, out_valid_reg && out_reg.error_code != ERR_NONE,
        out_reg.last, "error result is not marked last")
    `KPD_ASSERT_NOW(a_size_error_at_byte1, out_valid_reg && out_reg.error_code == ERR_SIZE,
        out_reg.byte_index == INDEX_W'(1), "size error reported away from byte one")
    `KPD_ASSERT_NEXT(a_restart_clears, s1_go && s1_action_reg,
        state_reg.byte_count == 16'd0 && state_reg.init_count == 2'd0,
        "restart request left parse state behind")

endmodule

/* hdl/kpd_step.sv */
// One parse step of the descrambler: next state and result for one request.
// Depends on kpd_pkg for the state and result types and the key ROM.
`timescale 1ns / 1ps

module kpd_step
    import kpd_pkg::*;
(
    input  kpd_state_t  cur,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    input  logic        require_init,
    input  logic [31:0] init_code,
    output kpd_state_t  nxt,
    output logic        has_result,
    output kpd_result_t result
);

    logic [15:0] idx;
    logic [15:0] size_full;
    logic [7:0]  tap;
    logic [7:0]  descrambled;
    logic [31:0] init_word;
    logic [7:0]  data_val;
    logic        last_hit;
    logic [7:0]  checksum;

    // Key tap and position-dependent adjustment for payload bytes.
    always_comb
    begin
        tap = key_tap(cur.key_position);
        case (cur.byte_count[1:0])
            2'd0:    descrambled = rx_byte - {tap[6:0], 1'b0};
            2'd1:    descrambled = rx_byte + {3'b000, tap[7:3]};
            2'd2:    descrambled = rx_byte - {tap[5:0], 2'b00};
            default: descrambled = rx_byte + {5'b00000, tap[7:5]};
        endcase
    end

    // State update and result selection.
    always_comb
    begin
        idx        = cur.byte_count;
        size_full  = {rx_byte, cur.message_size[7:0]};
        init_word  = {rx_byte, cur.init_shift[31:8]};
        nxt        = cur;
        has_result = 1'b0;
        data_val   = rx_byte;
        last_hit   = 1'b0;
        checksum   = '0;
        result.data_byte   = '0;
        result.byte_index  = '0;
        result.last        = 1'b0;
        result.error_code  = ERR_NONE;
        result.error_value = '0;

        if (action)
        begin
            nxt = restart_state(require_init);
        end
        else if (cur.init_pending)
        begin
            // Collect the little-endian init word.
            if (cur.init_count != 2'd3)
            begin
                nxt.init_shift = init_word;
                nxt.init_count = cur.init_count + 2'd1;
            end
            else
            begin
                nxt.init_count = '0;
                nxt.init_shift = '0;
                if (init_word == init_code)
                begin
                    nxt.init_pending = 1'b0;
                end
                else
                begin
                    has_result         = 1'b1;
                    result.last        = 1'b1;
                    result.error_code  = ERR_INIT;
                    result.error_value = init_word;
                end
            end
        end
        else if (idx == 16'd1 && (size_full > 16'(MAX_MSG_BYTES) ||
                                  size_full < 16'(HEADER_BYTES)))
        begin
            // Size out of range: report and resynchronize on the next byte.
            nxt.message_size   = size_full;
            nxt.byte_count     = '0;
            has_result         = 1'b1;
            result.data_byte   = rx_byte;
            result.byte_index  = INDEX_W'(1);
            result.last        = 1'b1;
            result.error_code  = ERR_SIZE;
            result.error_value = {16'd0, size_full};
        end
        else
        begin
            // Header fields, then descrambled payload.
            case (idx)
                16'd0:
                begin
                    nxt.message_size = {8'd0, rx_byte};
                    nxt.raw_sum      = '0;
                    nxt.plain_sum    = '0;
                end
                16'd1:   nxt.message_size      = size_full;
                16'd2:   nxt.key_position      = key_start(rx_byte);
                16'd3:   nxt.expected_checksum = rx_byte;
                default:
                begin
                    data_val         = descrambled;
                    nxt.raw_sum      = cur.raw_sum + rx_byte;
                    nxt.plain_sum    = cur.plain_sum + descrambled;
                    nxt.key_position = cur.key_position + 8'd1;
                end
            endcase

            last_hit = (idx >= 16'd2) &&
                       (({1'b0, idx} + 17'd1) == {1'b0, nxt.message_size});
            checksum = nxt.raw_sum - nxt.plain_sum;

            has_result        = 1'b1;
            result.data_byte  = data_val;
            result.byte_index = idx[INDEX_W-1:0];
            if (last_hit)
            begin
                nxt.byte_count = '0;
                result.last    = 1'b1;
                if (checksum != nxt.expected_checksum)
                begin
                    result.error_code  = ERR_CHECKSUM;
                    result.error_value = {16'd0, nxt.message_size};
                end
            end
            else
            begin
                nxt.byte_count = idx + 16'd1;
            end
        end
    end

endmodule
